// ----- hw/rtl/rle_pkg.sv -----
// rle_pkg: shared types and fixed constants of the run-length packet encoder
// depends on nothing; imported by rle_packet_encoder and the testbench
`default_nettype none

package rle_pkg;

  // packet count field, fixed by the seven count bits of a packet header
  localparam int CNT_W       = 7;
  // chunks that one input may produce at most; later chunks are dropped
  localparam int MAX_RESULTS = 17;
  localparam int RES_W       = 5;

  typedef enum logic [1:0] {
    MODE_NONE    = 2'd0,
    MODE_REPEAT  = 2'd1,
    MODE_LITERAL = 2'd2
  } mode_t;

endpackage

`default_nettype wire

// ----- hw/rtl/rle_ram.sv -----
// rle_ram: generic single-write, single-read RAM with a registered read port
// no package dependency; used for the literal byte store of the encoder
`default_nettype none

module rle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 127
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/rle_packet_encoder.sv -----
// rle_packet_encoder: byte-stream run-length encoder emitting packed chunks
// depends on rle_pkg and rle_ram (literal byte store)
//
// Usage:
//   Input channel (in_valid / in_stall): one raw byte per beat, with
//   in_stream_end on the final byte of a stream. Output channel
//   (out_valid / out_stall): chunks of up to CHUNK_BYTES compressed bytes,
//   first byte in bits 7:0, unused lanes zero. out_last_of_burst marks the
//   final chunk caused by one input beat, out_stream_done the chunk that holds
//   the final compressed byte of a stream.
//   One input beat is handled at a time. The assembly loop takes one
//   compressed byte at a time and the literal store has a single read port.
//   A literal of n bytes is read back from the store at one byte per cycle
//   after its header byte, while the assembly loop is not waiting.
//   Reset (rst_n low, synchronous) closes all packets, drops the held
//   lookahead byte and empties the output register; no clearing pass runs.
//   While the receiver stalls, the output register holds its chunk and the
//   assembly loop waits once the next chunk is full.
`default_nettype none

module rle_packet_encoder
  import rle_pkg::*;
#(
  parameter int MAX_PACKET  = 127,
  parameter int CHUNK_BYTES = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte_value,
  input  wire logic        in_stream_end,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      out_chunk_data,
  output logic [3:0]       out_chunk_bytes,
  output logic             out_last_of_burst,
  output logic             out_stream_done
);

  localparam int AW = $clog2(MAX_PACKET);

  typedef enum logic [2:0] {
    S_IDLE, S_ENC, S_REP_CNT, S_REP_VAL, S_LIT_HDR, S_LIT_PUT, S_FLUSH
  } state_t;

  // which byte is being encoded: held lookahead, final byte, or final close
  typedef enum logic [1:0] {
    PH_LA, PH_LAST, PH_FIN
  } phase_t;

  // where a packet close returns to
  typedef enum logic {
    RES_REDO, RES_ADVANCE
  } resume_t;

  state_t             state_r, state_nxt;
  phase_t             phase_r, phase_nxt;
  resume_t            resume_r, resume_nxt;
  logic [7:0]         la_r, la_nxt;
  logic               la_vld_r, la_vld_nxt;
  mode_t              mode_r, mode_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [7:0]         rv_r, rv_nxt;
  logic [7:0]         in_byte_r, in_byte_nxt;
  logic               in_last_r, in_last_nxt;
  logic [AW-1:0]      idx_r, idx_nxt;
  logic [63:0]        acc_data_r, acc_data_nxt;
  logic [3:0]         acc_cnt_r, acc_cnt_nxt;
  logic [RES_W-1:0]   chunk_idx_r, chunk_idx_nxt;
  logic               drop_r, drop_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [63:0]        out_data_r, out_data_nxt;
  logic [3:0]         out_bytes_r, out_bytes_nxt;
  logic               out_last_r, out_last_nxt;
  logic               out_done_r, out_done_nxt;

  logic               wr_en, rd_en;
  logic [AW-1:0]      wr_addr, rd_addr;
  logic [7:0]         wr_data, rd_data;

  logic [7:0]         enc_x;
  logic               has_next, eq_next;
  logic [CNT_W-1:0]   cnt_inc;
  logic               cnt_at_max;
  logic [AW-1:0]      idx_inc;
  logic               out_free, acc_full, can_put;
  logic               put_req;
  logic [7:0]         put_val;
  logic               push_req, push_last, push_done;
  state_t             adv_state;
  phase_t             adv_phase;

  rle_ram #(
    .WIDTH (8),
    .DEPTH (MAX_PACKET)
  ) u_lit_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign enc_x      = (phase_r == PH_LA) ? la_r : in_byte_r;
  assign has_next   = (phase_r == PH_LA);
  assign eq_next    = has_next && (enc_x == in_byte_r);
  assign cnt_inc    = cnt_r + CNT_W'(1);
  assign cnt_at_max = (cnt_inc >= CNT_W'(MAX_PACKET));
  assign idx_inc    = idx_r + AW'(1);
  assign out_free   = !out_valid_r || !out_stall;
  assign acc_full   = (acc_cnt_r == 4'(CHUNK_BYTES));
  assign can_put    = drop_r || !acc_full || out_free;

  // next step once the current byte is fully encoded
  always_comb begin
    adv_phase = phase_r;
    case (phase_r)
      PH_LA: begin
        if (in_last_r) begin
          adv_state = S_ENC;
          adv_phase = PH_LAST;
        end else begin
          adv_state = S_FLUSH;
        end
      end
      PH_LAST: begin
        adv_state = S_ENC;
        adv_phase = PH_FIN;
      end
      default: adv_state = S_FLUSH;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    resume_nxt    = resume_r;
    la_nxt        = la_r;
    la_vld_nxt    = la_vld_r;
    mode_nxt      = mode_r;
    cnt_nxt       = cnt_r;
    rv_nxt        = rv_r;
    in_byte_nxt   = in_byte_r;
    in_last_nxt   = in_last_r;
    idx_nxt       = idx_r;
    acc_data_nxt  = acc_data_r;
    acc_cnt_nxt   = acc_cnt_r;
    chunk_idx_nxt = chunk_idx_r;
    drop_nxt      = drop_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_bytes_nxt = out_bytes_r;
    out_last_nxt  = out_last_r;
    out_done_nxt  = out_done_r;
    wr_en         = 1'b0;
    wr_addr       = cnt_r[AW-1:0];
    wr_data       = enc_x;
    rd_en         = 1'b0;
    rd_addr       = idx_r;
    put_req       = 1'b0;
    put_val       = 8'd0;
    push_req      = 1'b0;
    push_last     = 1'b0;
    push_done     = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          in_byte_nxt = in_byte_value;
          in_last_nxt = in_stream_end;
          if (la_vld_r) begin
            state_nxt = S_ENC;
            phase_nxt = PH_LA;
          end else if (in_stream_end) begin
            state_nxt = S_ENC;
            phase_nxt = PH_LAST;
          end else begin
            state_nxt = S_FLUSH;
          end
        end
      end

      S_ENC: begin
        if (phase_r == PH_FIN) begin
          // a repeat can still be open after the final byte
          if (mode_r == MODE_REPEAT) begin
            state_nxt  = S_REP_CNT;
            resume_nxt = RES_ADVANCE;
          end else begin
            state_nxt = adv_state;
            phase_nxt = adv_phase;
          end
        end else begin
          case (mode_r)
            MODE_REPEAT: begin
              if (enc_x == rv_r) begin
                cnt_nxt = cnt_inc;
                if (cnt_at_max) begin
                  state_nxt  = S_REP_CNT;
                  resume_nxt = RES_ADVANCE;
                end else begin
                  state_nxt = adv_state;
                  phase_nxt = adv_phase;
                end
              end else begin
                state_nxt  = S_REP_CNT;
                resume_nxt = RES_REDO;
              end
            end
            MODE_LITERAL: begin
              if (eq_next) begin
                state_nxt  = S_LIT_HDR;
                resume_nxt = RES_REDO;
              end else begin
                wr_en   = 1'b1;
                cnt_nxt = cnt_inc;
                if (cnt_at_max || !has_next) begin
                  state_nxt  = S_LIT_HDR;
                  resume_nxt = RES_ADVANCE;
                end else begin
                  state_nxt = adv_state;
                  phase_nxt = adv_phase;
                end
              end
            end
            default: begin
              // no packet open: start one
              cnt_nxt = CNT_W'(1);
              if (eq_next) begin
                mode_nxt  = MODE_REPEAT;
                rv_nxt    = enc_x;
                state_nxt = adv_state;
                phase_nxt = adv_phase;
              end else begin
                mode_nxt = MODE_LITERAL;
                wr_en    = 1'b1;
                wr_addr  = '0;
                if (!has_next) begin
                  state_nxt  = S_LIT_HDR;
                  resume_nxt = RES_ADVANCE;
                end else begin
                  state_nxt = adv_state;
                  phase_nxt = adv_phase;
                end
              end
            end
          endcase
        end
      end

      S_REP_CNT: begin
        put_req = 1'b1;
        put_val = {1'b0, cnt_r};
        if (can_put) begin
          state_nxt = S_REP_VAL;
        end
      end

      S_REP_VAL: begin
        put_req = 1'b1;
        put_val = rv_r;
        if (can_put) begin
          mode_nxt = MODE_NONE;
          cnt_nxt  = '0;
          if (resume_r == RES_REDO) begin
            state_nxt = S_ENC;
          end else begin
            state_nxt = adv_state;
            phase_nxt = adv_phase;
          end
        end
      end

      S_LIT_HDR: begin
        put_req = 1'b1;
        put_val = {1'b1, cnt_r};
        if (can_put) begin
          rd_en     = 1'b1;
          rd_addr   = '0;
          idx_nxt   = '0;
          state_nxt = S_LIT_PUT;
        end
      end

      S_LIT_PUT: begin
        // read data holds while the loop waits, next read issued with each put
        put_req = 1'b1;
        put_val = rd_data;
        if (can_put) begin
          if (CNT_W'(idx_r) + CNT_W'(1) < cnt_r) begin
            rd_en   = 1'b1;
            rd_addr = idx_inc;
            idx_nxt = idx_inc;
          end else begin
            mode_nxt = MODE_NONE;
            cnt_nxt  = '0;
            if (resume_r == RES_REDO) begin
              state_nxt = S_ENC;
            end else begin
              state_nxt = adv_state;
              phase_nxt = adv_phase;
            end
          end
        end
      end

      S_FLUSH: begin
        if (drop_r || acc_cnt_r == 4'd0 || out_free) begin
          if (!drop_r && acc_cnt_r != 4'd0) begin
            push_req  = 1'b1;
            push_last = 1'b1;
            push_done = in_last_r;
          end
          acc_data_nxt  = '0;
          acc_cnt_nxt   = '0;
          chunk_idx_nxt = '0;
          drop_nxt      = 1'b0;
          if (in_last_r) begin
            la_nxt     = 8'd0;
            la_vld_nxt = 1'b0;
            mode_nxt   = MODE_NONE;
            cnt_nxt    = '0;
            rv_nxt     = 8'd0;
          end else begin
            la_nxt     = in_byte_r;
            la_vld_nxt = 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // chunk assembly: a full chunk leaves when the next byte arrives or the beat is flushed
    if (put_req && can_put && !drop_r) begin
      if (acc_full) begin
        push_req      = 1'b1;
        push_last     = (chunk_idx_r == RES_W'(MAX_RESULTS - 1));
        push_done     = push_last && in_last_r;
        chunk_idx_nxt = chunk_idx_r + RES_W'(1);
        if (push_last) begin
          drop_nxt     = 1'b1;
          acc_data_nxt = '0;
          acc_cnt_nxt  = '0;
        end else begin
          acc_data_nxt = 64'(put_val);
          acc_cnt_nxt  = 4'd1;
        end
      end else begin
        acc_data_nxt = acc_data_r | (64'(put_val) << {acc_cnt_r[2:0], 3'b000});
        acc_cnt_nxt  = acc_cnt_r + 4'd1;
      end
    end

    if (push_req) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = acc_data_r;
      out_bytes_nxt = acc_cnt_r;
      out_last_nxt  = push_last;
      out_done_nxt  = push_done;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_LA;
      resume_r    <= RES_REDO;
      la_r        <= 8'd0;
      la_vld_r    <= 1'b0;
      mode_r      <= MODE_NONE;
      cnt_r       <= '0;
      rv_r        <= 8'd0;
      in_byte_r   <= 8'd0;
      in_last_r   <= 1'b0;
      idx_r       <= '0;
      acc_data_r  <= '0;
      acc_cnt_r   <= '0;
      chunk_idx_r <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
      out_bytes_r <= '0;
      out_last_r  <= 1'b0;
      out_done_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      resume_r    <= resume_nxt;
      la_r        <= la_nxt;
      la_vld_r    <= la_vld_nxt;
      mode_r      <= mode_nxt;
      cnt_r       <= cnt_nxt;
      rv_r        <= rv_nxt;
      in_byte_r   <= in_byte_nxt;
      in_last_r   <= in_last_nxt;
      idx_r       <= idx_nxt;
      acc_data_r  <= acc_data_nxt;
      acc_cnt_r   <= acc_cnt_nxt;
      chunk_idx_r <= chunk_idx_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
      out_data_r  <= out_data_nxt;
      out_bytes_r <= out_bytes_nxt;
      out_last_r  <= out_last_nxt;
      out_done_r  <= out_done_nxt;
    end
  end

  assign in_stall          = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_chunk_data    = out_data_r;
  assign out_chunk_bytes   = out_bytes_r;
  assign out_last_of_burst = out_last_r;
  assign out_stream_done   = out_done_r;

  // a chunk never carries zero bytes or more than a chunk's worth
  a_chunk_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_bytes_r != 4'd0) && (out_bytes_r <= 4'(CHUNK_BYTES)))
    else $error("chunk byte count out of range");

  // end of stream is only flagged on the closing chunk of a burst
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_done_r) |-> out_last_r)
    else $error("stream_done without last_of_burst");

  // an open packet between encode steps holds at least one and fewer than max bytes
  a_open_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ENC && mode_r != MODE_NONE) |->
      (cnt_r != '0) && (cnt_r < CNT_W'(MAX_PACKET)))
    else $error("open packet count out of range");

  // the assembler is empty between beats
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (acc_cnt_r == 4'd0) && !drop_r && (chunk_idx_r == '0))
    else $error("chunk assembler not empty while idle");

  // dropping starts only after the chunk limit has been reached
  a_drop_limit: assert property (@(posedge clk) disable iff (!rst_n)
    drop_r |-> (chunk_idx_r == RES_W'(MAX_RESULTS)))
    else $error("chunks dropped before the limit");

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
// testbench: self-checking bench for rle_packet_encoder, the run-length packet encoder
// mirrors the encoder in a behavioral model and checks every chunk; depends on rle_pkg
`timescale 1ns / 1ps

module testbench;
  import rle_pkg::*;

  localparam int PKT_MAX     = 127;
  localparam int CHUNK       = 8;
  localparam int QUIET_LIMIT = 3000;
  localparam int TAIL_CYCLES = 300;
  localparam int RANDOM_BEATS = 500;

  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  nbytes;
    logic        last;
    logic        done;
  } chunk_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte_value = 8'h00;
  logic        in_stream_end = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_chunk_data;
  logic [3:0]  out_chunk_bytes;
  logic        out_last_of_burst;
  logic        out_stream_done;

  rle_packet_encoder #(
    .MAX_PACKET (PKT_MAX),
    .CHUNK_BYTES(CHUNK)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte_value    (in_byte_value),
    .in_stream_end    (in_stream_end),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_chunk_data   (out_chunk_data),
    .out_chunk_bytes  (out_chunk_bytes),
    .out_last_of_burst(out_last_of_burst),
    .out_stream_done  (out_stream_done)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // encoder state as seen by the predictor
  logic [7:0] held_byte;
  bit         held_valid;
  mode_t      open_mode;
  int         open_count;
  logic [7:0] run_value;
  logic [7:0] literal_bytes [PKT_MAX];
  logic [7:0] coded_bytes [$];
  chunk_t     expected_chunks [$];

  int mismatch_count = 0;
  int burst_left = 0;
  bit idle_on = 1'b1;
  int quiet_cycles = 0;
  int stall_left = 0;
  int stall_kind = 0;

  initial begin
    held_byte  = 8'h00;
    held_valid = 1'b0;
    open_mode  = MODE_NONE;
    open_count = 0;
    run_value  = 8'h00;
  end

  function automatic void flush_repeat();
    coded_bytes.push_back(8'(open_count));
    coded_bytes.push_back(run_value);
    open_mode  = MODE_NONE;
    open_count = 0;
  endfunction

  function automatic void flush_literal();
    coded_bytes.push_back(8'(open_count) | 8'h80);
    for (int k = 0; k < open_count; k++) coded_bytes.push_back(literal_bytes[k]);
    open_mode  = MODE_NONE;
    open_count = 0;
  endfunction

  // decide byte x, with nx the byte that follows it when has_next is set
  function automatic void code_byte(input logic [7:0] x, input bit has_next,
                                    input logic [7:0] nx);
    if (open_mode == MODE_REPEAT) begin
      if (x == run_value) begin
        open_count++;
        if (open_count >= PKT_MAX) flush_repeat();
        return;
      end
      flush_repeat();
    end else if (open_mode == MODE_LITERAL) begin
      if (has_next && x == nx) begin
        flush_literal();
      end else begin
        literal_bytes[open_count] = x;
        open_count++;
        if (open_count >= PKT_MAX || !has_next) flush_literal();
        return;
      end
    end
    if (has_next && x == nx) begin
      open_mode  = MODE_REPEAT;
      run_value  = x;
      open_count = 1;
    end else begin
      open_mode        = MODE_LITERAL;
      literal_bytes[0] = x;
      open_count       = 1;
      if (!has_next) flush_literal();
    end
  endfunction

  // run one accepted beat through the model and queue the chunks it yields
  function automatic void encode_beat(input logic [7:0] b, input bit fin);
    int n_chunks;
    int pos;
    int cnt;
    chunk_t c;
    coded_bytes.delete();
    if (held_valid) code_byte(held_byte, 1'b1, b);
    if (fin) begin
      code_byte(b, 1'b0, 8'h00);
      if (open_mode == MODE_REPEAT) flush_repeat();
      else if (open_mode == MODE_LITERAL) flush_literal();
      held_byte  = 8'h00;
      held_valid = 1'b0;
      open_mode  = MODE_NONE;
      open_count = 0;
      run_value  = 8'h00;
    end else begin
      held_byte  = b;
      held_valid = 1'b1;
    end
    n_chunks = (coded_bytes.size() + CHUNK - 1) / CHUNK;
    if (n_chunks > MAX_RESULTS) n_chunks = MAX_RESULTS;
    pos = 0;
    for (int k = 0; k < n_chunks; k++) begin
      cnt = coded_bytes.size() - pos;
      if (cnt > CHUNK) cnt = CHUNK;
      c = '0;
      for (int j = 0; j < cnt; j++) c.data[8*j +: 8] = coded_bytes[pos + j];
      c.nbytes = 4'(cnt);
      c.last   = (k == n_chunks - 1);
      c.done   = c.last && fin;
      expected_chunks.push_back(c);
      pos += cnt;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) encode_beat(in_byte_value, in_stream_end);
  end

  always @(posedge clk) begin
    chunk_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_chunks.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected chunk, expected none, actual data=%h bytes=%0d",
                 $time, out_chunk_data, out_chunk_bytes);
      end else begin
        want = expected_chunks.pop_front();
        if (out_chunk_data !== want.data) begin
          mismatch_count++;
          $display("%0t: chunk_data expected %h actual %h", $time, want.data, out_chunk_data);
        end
        if (out_chunk_bytes !== want.nbytes) begin
          mismatch_count++;
          $display("%0t: chunk_bytes expected %0d actual %0d",
                   $time, want.nbytes, out_chunk_bytes);
        end
        if (out_last_of_burst !== want.last) begin
          mismatch_count++;
          $display("%0t: last_of_burst expected %0b actual %0b",
                   $time, want.last, out_last_of_burst);
        end
        if (out_stream_done !== want.done) begin
          mismatch_count++;
          $display("%0t: stream_done expected %0b actual %0b",
                   $time, want.done, out_stream_done);
        end
      end
    end
  end

  // receiver: segments of free flow, solid stall and per-cycle coin flips
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_kind = $urandom_range(0, 2);
      stall_left = (stall_kind == 1) ? $urandom_range(1, 20) : $urandom_range(5, 60);
    end
    stall_left--;
    case (stall_kind)
      0: out_stall <= 1'b0;
      1: out_stall <= 1'b1;
      default: out_stall <= ($urandom_range(0, 1) == 1);
    endcase
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input bit fin);
    int gap;
    if (burst_left == 0) begin
      burst_left = idle_on ? $urandom_range(1, 12) : 1000;
      gap = idle_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid      <= 1'b1;
    in_byte_value <= b;
    in_stream_end <= fin;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic go_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (expected_chunks.size() != 0) @(posedge clk);
  endtask

  task automatic send_list(input logic [7:0] vals [$]);
    for (int i = 0; i < vals.size(); i++) send_byte(vals[i], i == vals.size() - 1);
  endtask

  task automatic test_short_streams();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_list('{8'hAA, 8'hAA});
    send_list('{8'h01, 8'h02});
  endtask

  task automatic test_runs_and_literals();
    send_list('{8'h10, 8'h20, 8'h30, 8'h30, 8'h30, 8'h40});
    send_list('{8'h7F, 8'h7F, 8'h80, 8'h80, 8'h00});
    send_list('{8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00});
    // pressure: hold off until the encoder has caught up
    go_idle();
    wait_drained();
  endtask

  task automatic test_repeat_limit();
    // run fills a packet, next equal byte opens a fresh one
    for (int i = 0; i < 129; i++) send_byte(8'h5A, 1'b0);
    send_byte(8'hC3, 1'b1);
    for (int i = 0; i < PKT_MAX; i++) send_byte(8'hE7, i == PKT_MAX - 1);
  endtask

  task automatic test_literal_limit();
    for (int i = 0; i < 130; i++) send_byte(8'(i * 37), i == 129);
    for (int i = 0; i < PKT_MAX; i++) send_byte(8'(255 - i), i == PKT_MAX - 1);
  endtask

  task automatic test_random_streams();
    int sent;
    int len;
    int run;
    int r;
    int alphabet;
    bit paused;
    logic [7:0] value;
    sent = 0;
    paused = 1'b0;
    while (sent < RANDOM_BEATS) begin
      idle_on = ($urandom_range(0, 3) != 0);
      r = $urandom_range(0, 99);
      if (r < 80) len = $urandom_range(1, 24);
      else if (r < 95) len = $urandom_range(25, 80);
      else len = $urandom_range(150, 260);
      alphabet = ($urandom_range(0, 1) == 1) ? $urandom_range(1, 4) : 255;
      for (int i = 0; i < len; ) begin
        value = 8'($urandom_range(0, alphabet));
        if (alphabet == 255) value = 8'($urandom);
        r = $urandom_range(0, 99);
        if (r < 55) run = 1;
        else if (r < 90) run = $urandom_range(2, 6);
        else if (r < 97) run = $urandom_range(7, 40);
        else run = $urandom_range(120, 135);
        for (int k = 0; k < run && i < len; k++, i++) send_byte(value, i == len - 1);
      end
      sent += len;
      if (!paused && sent >= RANDOM_BEATS / 2) begin
        go_idle();
        wait_drained();
        paused = 1'b1;
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_short_streams();
    test_runs_and_literals();
    test_repeat_limit();
    test_literal_limit();
    test_random_streams();
    go_idle();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_chunks.size() != 0) begin
      mismatch_count++;
      $display("%0t: %0d expected chunks never arrived", $time, expected_chunks.size());
    end
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
